// File: rtl/isb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isb_pkg
// shared constants and controller/datapath handshake types for the sorter
// ----------------------------------------------------------------------------
package isb_pkg;

  localparam int unsigned MaxItems = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CntW     = $clog2(MaxItems + 1);

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [CntW-1:0]         cnt_t;

  typedef enum logic [1:0] {
    ST_FILL = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  typedef struct packed {
    logic insert;
    logic pop;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic one_left;
  } status_t;

endpackage

// File: rtl/isb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isb_dp
// row of compare-and-shift cells, fill count, drop flag and output register
// ----------------------------------------------------------------------------
module isb_dp import isb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  output status_t status_o,
  input  data_t   value_i,
  output data_t   sorted_value_o,
  output logic    final_res_o,
  output logic    overflowed_o,
  output logic    valid_o,
  input  logic    ready_i
);

  data_t          cell_q [MaxItems];
  data_t          cell_d [MaxItems];
  logic [MaxItems-1:0] take;
  cnt_t           count_q, count_d;
  logic           drop_q, drop_d;
  logic           full;
  logic           valid_q, valid_d;
  data_t          out_data_q;
  logic           out_last_q;
  logic           out_ovf_q;

  assign full = (count_q == cnt_t'(MaxItems));

  always_comb begin
    for (int i = 0; i < MaxItems; i++) begin
      take[i] = ((cnt_t'(i) < count_q) && (cell_q[i] > value_i)) ||
                (cnt_t'(i) == count_q);
    end
  end

  always_comb begin
    for (int i = 0; i < MaxItems; i++) begin
      cell_d[i] = cell_q[i];
      if (cmd_i.insert && !full) begin
        if (take[i]) begin
          if (i > 0 && take[(i > 0) ? i - 1 : 0]) begin
            cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
          end else begin
            cell_d[i] = value_i;
          end
        end
      end else if (cmd_i.pop && i < MaxItems - 1) begin
        cell_d[i] = cell_q[(i < MaxItems - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    if (cmd_i.insert) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        count_d = count_q + cnt_t'(1);
      end
    end else if (cmd_i.pop) begin
      count_d = count_q - cnt_t'(1);
    end
    if (cmd_i.clear) begin
      drop_d = 1'b0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.pop) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxItems; i++) begin
      cell_q[i] <= cell_d[i];
    end
    if (cmd_i.pop) begin
      out_data_q <= cell_q[0];
      out_last_q <= (count_q == cnt_t'(1));
      out_ovf_q  <= drop_q;
    end
  end

  assign status_o.out_free = !valid_q || ready_i;
  assign status_o.one_left = (count_q == cnt_t'(1));

  assign sorted_value_o = out_data_q;
  assign final_res_o    = out_last_q;
  assign overflowed_o   = out_ovf_q;
  assign valid_o        = valid_q;

endmodule

// File: rtl/isb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isb_ctrl
// fill/emit sequencer driving the sorter datapath
// ----------------------------------------------------------------------------
module isb_ctrl import isb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_FILL: begin
        in_ready_o   = 1'b1;
        cmd_o.insert = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.pop = status_i.out_free;
        if (status_i.out_free && status_i.one_left) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_FILL;
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/insertion_sort_block.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sort_block
// streaming insertion sorter for signed 32-bit values
// ----------------------------------------------------------------------------
// input beats carry one value each (s_axis_tdata) and s_axis_tlast marks the
// last value of a set. each value is inserted into a row of
// 16 compare-and-shift cells; equal values keep arrival order. values that
// arrive while the row is full are dropped and the set is marked overflowed.
// after the tlast beat the block stops taking input and emits the set in
// ascending order on m_axis, one beat per cycle while the receiver is ready,
// with m_axis_tlast on the final beat and m_axis_tuser high on every beat of
// an overflowed set. while filling, a beat is taken whenever one is offered.
// the row keeps up to 16 values of a set, drained through the single
// output register while the cell row shifts down one place per beat. the first
// result is popped once the emit state is entered and the output register is
// free. a stalled receiver holds the output register and pauses the drain;
// input is taken again as soon as the last result sits in the output
// register. reset empties the row, clears the overflow mark and m_axis_tvalid.
// ----------------------------------------------------------------------------
module insertion_sort_block import isb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,   // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
  output logic        m_axis_tlast,   // final_res
  output logic        m_axis_tuser    // [0] overflowed
);

  cmd_t    cmd;
  status_t status;

  isb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  isb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .value_i        (s_axis_tdata),
    .sorted_value_o (m_axis_tdata),
    .final_res_o    (m_axis_tlast),
    .overflowed_o   (m_axis_tuser),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready)
  );

endmodule

// File: tb/insertion_sort_block_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sort_block_tb
// self-checking bench for the streaming insertion sorter
// ----------------------------------------------------------------------------
// value beats go in on s_axis, with tlast closing each set. a software copy of
// the sorted row predicts every output beat: its value, the final-beat mark
// and the overflow mark. the named tests cover extreme values, an exactly
// full row, overflow with a dropped tlast value, random sets, a long receiver
// hold-off that backs up the input, and a sender pause until the drain ends.
// ----------------------------------------------------------------------------
module insertion_sort_block_tb;
  import isb_pkg::*;

  typedef struct packed {
    data_t sorted;
    logic  fin;
    logic  ovf;
  } sorted_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] value
  logic        s_axis_tlast;   // last_item
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] sorted_value
  logic        m_axis_tlast;   // final_res
  logic        m_axis_tuser;   // [0] overflowed

  data_t        sort_row [MaxItems];
  int unsigned  row_count;
  logic         row_dropped;
  sorted_beat_t sorted_q [$];
  int unsigned  errors;
  int unsigned  beats_sent;
  int unsigned  rx_hold;
  int unsigned  rx_run;

  insertion_sort_block dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // insert one value into the row; a tlast beat releases the whole set
  task automatic insert_and_emit(input data_t v, input logic last);
    int unsigned  pos;
    sorted_beat_t b;
    if (row_count >= MaxItems) begin
      row_dropped = 1'b1;
    end else begin
      pos = row_count;
      while (pos > 0 && sort_row[pos-1] > v) begin
        sort_row[pos] = sort_row[pos-1];
        pos--;
      end
      sort_row[pos] = v;
      row_count++;
    end
    if (last) begin
      for (int unsigned k = 0; k < row_count; k++) begin
        b.sorted = sort_row[k];
        b.fin    = (k + 1 == row_count);
        b.ovf    = row_dropped;
        sorted_q.push_back(b);
      end
      row_count   = 0;
      row_dropped = 1'b0;
    end
  endtask

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic data_t rand_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      1: return data_t'(int'($urandom_range(0, 15)) - 8);
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic send_value(input data_t v, input logic last, input int unsigned gap);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = v;
    s_axis_tlast  = last;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    insert_and_emit(v, last);
    beats_sent++;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_set(input int unsigned n, input bit steady);
    for (int unsigned i = 0; i < n; i++) begin
      send_value(rand_value(), i == n - 1, steady ? 0 : rand_gap());
    end
  endtask

  // stop offering the last beat again while the drain runs
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sorted_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    data_t vals [8];
    vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1, -32'sd1,
             32'sh5555_5555, 32'shAAAA_AAAA};
    for (int i = 0; i < 8; i++) send_value(vals[i], i == 7, rand_gap());
    send_value(32'sh8000_0000, 1'b1, rand_gap());
    send_value(32'sh7FFF_FFFF, 1'b1, rand_gap());
  endtask

  // descending order forces the longest shift on every insert
  task automatic test_full_row();
    for (int i = 0; i < MaxItems; i++) begin
      send_value(data_t'(MaxItems - i) - 32'sd5, i == MaxItems - 1, rand_gap());
    end
  endtask

  // tlast arrives on a full row and is itself dropped
  task automatic test_overflow();
    for (int i = 0; i < MaxItems + 2; i++) begin
      send_value(rand_value(), i == MaxItems + 1, rand_gap());
    end
    send_set(MaxItems + 1, 1'b1);
  endtask

  task automatic test_backpressure();
    @(posedge clk_i);
    rx_hold = 120;
    send_set(MaxItems, 1'b1);
    send_set(MaxItems / 2, 1'b1);
    send_set(3, 1'b1);
  endtask

  task automatic test_drain_pause();
    send_set(5, 1'b0);
    wait_drained();
    send_set(MaxItems, 1'b1);
    wait_drained();
    send_set(1, 1'b0);
  endtask

  task automatic test_random_sets();
    int unsigned r;
    while (beats_sent < 220) begin
      r = $urandom_range(0, 99);
      if (r < 10) send_set(MaxItems + $urandom_range(1, 4), $urandom_range(0, 4) == 0);
      else if (r < 20) send_set(1, $urandom_range(0, 4) == 0);
      else send_set($urandom_range(2, MaxItems), $urandom_range(0, 4) == 0);
    end
  endtask

  // receiver: runs of ready and stalls, plus a counted hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready = 1'b0;
      rx_hold--;
    end else if (rx_run == 0) begin
      m_axis_tready = ~m_axis_tready;
      rx_run = m_axis_tready ? $urandom_range(1, 40) : rand_gap();
    end else begin
      rx_run--;
    end
  end

  always @(posedge clk_i) begin
    sorted_beat_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sorted_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: data %0d last %b user %b", $time,
                 $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
      end else begin
        e = sorted_q.pop_front();
        if (m_axis_tdata !== e.sorted) begin
          errors++;
          $display("%0t: sorted_value expected %0d actual %0d", $time, e.sorted,
                   $signed(m_axis_tdata));
        end
        if (m_axis_tlast !== e.fin) begin
          errors++;
          $display("%0t: final_res expected %b actual %b", $time, e.fin, m_axis_tlast);
        end
        if (m_axis_tuser !== e.ovf) begin
          errors++;
          $display("%0t: overflowed expected %b actual %b", $time, e.ovf, m_axis_tuser);
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    row_count     = 0;
    row_dropped   = 1'b0;
    errors        = 0;
    beats_sent    = 0;
    rx_hold       = 0;
    rx_run        = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_full_row();
    test_overflow();
    test_backpressure();
    test_drain_pause();
    test_random_sets();

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
